// ===== sv/dwlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Duplicate word line checker package
// Shared types, codes and default sizes for the line checker modules.
// ----------------------------------------------------------------------------
package dwlc_pkg;

    localparam int WORDS_PER_LINE_DEF = 20;
    localparam int COMPARE_LENGTH_DEF = 20;
    localparam int QUEUE_DEPTH        = 2;
    localparam int SEEN_W             = 5;
    localparam int COUNT_W            = 32;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic               line_valid;
        logic [1:0]         status;
        logic [SEEN_W-1:0]  words_seen;
        logic [COUNT_W-1:0] valid_lines;
    } t_out_item;

    typedef struct packed {
        logic has_word;
        logic line_end;
    } t_cmd_flags;

    localparam int CMD_FLAGS_W = $bits(t_cmd_flags);

endpackage

// ===== sv/duplicate_word_line_checker.sv =====
// ----------------------------------------------------------------------------
// Duplicate word line checker
// Checks each text line for a repeated word and keeps a count of good lines.
// ----------------------------------------------------------------------------
// The front end takes one text byte per cycle while its two-entry command
// queue has room; it sends one command per closed word or line end. The back
// end compares each word with the words stored for the line, one stored word
// read from the word RAM per cycle, so the byte rate holds as long as words
// are long compared to the number stored on the line. The word RAM needs no
// clearing after reset; results come one per line end from an output
// register.
module duplicate_word_line_checker #(
    parameter int WORDS_PER_LINE = dwlc_pkg::WORDS_PER_LINE_DEF,
    parameter int COMPARE_LENGTH = dwlc_pkg::COMPARE_LENGTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dwlc_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dwlc_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    import dwlc_pkg::*;

    localparam int LEN_W  = $clog2(COMPARE_LENGTH + 1);
    localparam int WORD_W = COMPARE_LENGTH * 8;
    localparam int CMD_W  = CMD_FLAGS_W + WORD_W + LEN_W;

    logic               w_push;
    t_cmd_flags         w_push_flags;
    logic [WORD_W-1:0]  w_push_word;
    logic [LEN_W-1:0]   w_push_len;
    logic               w_q_full;
    logic               w_q_valid;
    logic [CMD_W-1:0]   w_q_data;
    logic               w_pop;
    t_cmd_flags         w_head_flags;
    logic [WORD_W-1:0]  w_head_word;
    logic [LEN_W-1:0]   w_head_len;

    dwlc_front #(
        .COMPARE_LENGTH (COMPARE_LENGTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_flags    (w_push_flags),
        .o_word     (w_push_word),
        .o_len      (w_push_len)
    );

    dwlc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_flags, w_push_word, w_push_len}),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_full  (w_q_full)
    );

    assign {w_head_flags, w_head_word, w_head_len} = w_q_data;

    dwlc_back #(
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .COMPARE_LENGTH (COMPARE_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd_flags (w_head_flags),
        .i_cmd_word  (w_head_word),
        .i_cmd_len   (w_head_len),
        .o_cmd_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== sv/dwlc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dwlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/dwlc_front.sv =====
// ----------------------------------------------------------------------------
// Line checker front end
// Splits the byte stream into words, cuts each to the compare length and
// issues one command per closed word or line end.
// ----------------------------------------------------------------------------
module dwlc_front #(
    parameter int COMPARE_LENGTH = 20,
    parameter int LEN_W = $clog2(COMPARE_LENGTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  dwlc_pkg::t_in_item          i_in_data,
    input  logic                        i_q_full,
    output logic                        o_in_stall,
    output logic                        o_push,
    output dwlc_pkg::t_cmd_flags        o_flags,
    output logic [COMPARE_LENGTH*8-1:0] o_word,
    output logic [LEN_W-1:0]            o_len
);

    import dwlc_pkg::*;

    logic [7:0]       r_word [COMPARE_LENGTH];
    logic [7:0]       n_word [COMPARE_LENGTH];
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_in_word;
    logic             w_accept;
    logic             w_is_nl;
    logic             w_is_sep;
    logic             w_close_line;

    always_comb begin
        w_accept     = i_in_valid && !i_q_full;
        w_is_nl      = (i_in_data.char_byte == CHAR_NEWLINE);
        w_is_sep     = w_is_nl || (i_in_data.char_byte == CHAR_SPACE);
        w_close_line = w_is_nl || i_in_data.line_end;

        n_len = r_len;
        for (int k = 0; k < COMPARE_LENGTH; k++) begin
            n_word[k] = r_word[k];
            if (!w_is_sep && (r_len == LEN_W'(k))) begin
                n_word[k] = i_in_data.char_byte;
            end
        end
        if (!w_is_sep && (r_len < LEN_W'(COMPARE_LENGTH))) begin
            n_len = r_len + LEN_W'(1);
        end

        o_push           = w_accept && ((w_is_sep && r_in_word) || w_close_line);
        o_flags.has_word = w_is_sep ? r_in_word : 1'b1;
        o_flags.line_end = w_close_line;
        for (int k = 0; k < COMPARE_LENGTH; k++) begin
            o_word[k*8 +: 8] = (LEN_W'(k) < n_len) ? n_word[k] : 8'd0;
        end
        o_len = n_len;
    end

    assign o_in_stall = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_in_word <= 1'b0;
        end else if (w_accept) begin
            if (o_push) begin
                r_len     <= '0;
                r_in_word <= 1'b0;
            end else if (!w_is_sep) begin
                r_len     <= n_len;
                r_in_word <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== sv/dwlc_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module dwlc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/dwlc_back.sv =====
// ----------------------------------------------------------------------------
// Line checker back end
// Compares each closed word with the words stored for the line, one stored
// word per cycle, and reports the line status at each line end.
// ----------------------------------------------------------------------------
module dwlc_back #(
    parameter int WORDS_PER_LINE = 20,
    parameter int COMPARE_LENGTH = 20,
    parameter int LEN_W = $clog2(COMPARE_LENGTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  dwlc_pkg::t_cmd_flags        i_cmd_flags,
    input  logic [COMPARE_LENGTH*8-1:0] i_cmd_word,
    input  logic [LEN_W-1:0]            i_cmd_len,
    output logic                        o_cmd_pop,
    output logic                        o_out_valid,
    output dwlc_pkg::t_out_item         o_out_data,
    input  logic                        i_out_stall
);

    import dwlc_pkg::*;

    localparam int ROW_W  = LEN_W + COMPARE_LENGTH * 8;
    localparam int ADDR_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int STORE_W = $clog2(WORDS_PER_LINE + 1);
    localparam int EXT_W  = STORE_W + SEEN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LINE
    } t_state;

    t_state             r_state;
    logic [STORE_W-1:0] r_stored;
    logic [STORE_W-1:0] r_idx;
    logic               r_pend;
    logic               r_dup;
    logic               r_ovf;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [ROW_W-1:0]   w_head_row;
    logic [ROW_W-1:0]   w_rd_data;
    logic               w_match;
    logic               w_scan_done;
    logic               w_rd_en;
    logic               w_wr_en;
    logic               w_word_live;
    logic               w_out_free;
    logic               w_line_ok;
    logic [COUNT_W-1:0] n_count;
    logic [EXT_W-1:0]   w_seen_ext;
    logic [SEEN_W-1:0]  w_seen;
    logic [1:0]         w_status;

    always_comb begin
        w_head_row  = {i_cmd_len, i_cmd_word};
        w_match     = r_pend && (w_rd_data == w_head_row);
        w_scan_done = (r_idx == r_stored);
        w_rd_en     = (r_state == S_SCAN) && !w_match && !w_scan_done;
        w_wr_en     = (r_state == S_SCAN) && !w_match && w_scan_done && !r_pend;
        w_word_live = i_cmd_flags.has_word && !r_dup && !r_ovf;
        w_out_free  = !r_out_valid || !i_out_stall;
        w_line_ok   = !r_dup && !r_ovf && (r_stored != '0);
        n_count     = (w_line_ok && (r_count != '1)) ? r_count + COUNT_W'(1) : r_count;
        w_seen_ext  = EXT_W'(r_stored);
        w_seen      = (w_seen_ext > EXT_W'(31)) ? SEEN_W'(31) : w_seen_ext[SEEN_W-1:0];
        if (r_ovf) begin
            w_status = STATUS_OVERFLOW;
        end else if (r_stored == '0) begin
            w_status = STATUS_EMPTY;
        end else begin
            w_status = STATUS_OK;
        end
        o_cmd_pop = (r_state == S_LINE) && i_cmd_valid
                    && (!i_cmd_flags.line_end || w_out_free);
    end

    dwlc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WORDS_PER_LINE)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_stored[ADDR_W-1:0]),
        .i_wr_data (w_head_row),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stored    <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_dup       <= 1'b0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop && i_cmd_flags.line_end) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (w_word_live && (r_stored >= STORE_W'(WORDS_PER_LINE))) begin
                            r_ovf   <= 1'b1;
                            r_state <= S_LINE;
                        end else if (w_word_live) begin
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_LINE;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_match) begin
                        r_dup   <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= S_LINE;
                    end else if (w_scan_done) begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_stored <= r_stored + STORE_W'(1);
                            r_state  <= S_LINE;
                        end
                    end else begin
                        r_idx  <= r_idx + STORE_W'(1);
                        r_pend <= 1'b1;
                    end
                end
                S_LINE: begin
                    if (o_cmd_pop) begin
                        r_state <= S_IDLE;
                        if (i_cmd_flags.line_end) begin
                            r_count     <= n_count;
                            r_stored    <= '0;
                            r_dup       <= 1'b0;
                            r_ovf       <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_LINE) && o_cmd_pop && i_cmd_flags.line_end) begin
            r_out_data.line_valid  <= w_line_ok;
            r_out_data.status      <= w_status;
            r_out_data.words_seen  <= w_seen;
            r_out_data.valid_lines <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/dwlc_checker.sv =====
// ----------------------------------------------------------------------------
// Line checker port checker
// Concurrent checks on the top level ports, attached by bind.
// ----------------------------------------------------------------------------
module dwlc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input dwlc_pkg::t_out_item i_out_data,
    input logic                i_out_stall
);

    import dwlc_pkg::*;

    a_ctrl_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_in_stall, i_out_valid}))
        else $error("unknown stall or valid");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled transfer changed");

    a_valid_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.line_valid |->
            (i_out_data.status == STATUS_OK) && (i_out_data.words_seen != '0)
            && (i_out_data.valid_lines != '0))
        else $error("valid line with bad status or count");

    a_empty_no_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == STATUS_EMPTY) |->
            (i_out_data.words_seen == '0) && !i_out_data.line_valid)
        else $error("empty line reports words");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.status == STATUS_OK)
            || (i_out_data.status == STATUS_EMPTY)
            || (i_out_data.status == STATUS_OVERFLOW))
        else $error("unknown status code");

endmodule

bind duplicate_word_line_checker dwlc_checker u_dwlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Duplicate word line checker testbench
// Streams text bytes into the checker and compares every line result against
// a behavioral prediction kept in a small scoreboard. A short directed part
// covers empty lines, repeats, flag-closed lines and the byte extremes; random
// lines then mix repeats, full and overflowing lines, long words that only
// differ past the compare length, and raw noise, under random idles and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import dwlc_pkg::*;

    localparam int NWORDS     = WORDS_PER_LINE_DEF;
    localparam int NCMP       = COMPARE_LENGTH_DEF;
    localparam int BYTE_COUNT = 1800;
    localparam int IDLE_LIMIT = 5000;

    class line_scoreboard;
        logic [7:0]  stored_text [NWORDS][NCMP];
        int unsigned stored_len [NWORDS];
        logic [7:0]  word_buf [NCMP];
        int unsigned word_len     = 0;
        int unsigned kept_words   = 0;
        bit          in_word      = 0;
        bit          repeat_hit   = 0;
        bit          overflow_hit = 0;
        logic [COUNT_W-1:0] good_lines = '0;
        t_out_item   expected_q[$];
        int unsigned mismatches = 0;
        int unsigned n_good = 0, n_repeat = 0, n_empty = 0, n_overflow = 0;

        function bit slot_equal(int slot);
            if (stored_len[slot] != word_len) return 0;
            for (int k = 0; k < word_len; k++) begin
                if (stored_text[slot][k] != word_buf[k]) return 0;
            end
            return 1;
        endfunction

        function void finish_word();
            if (!in_word) return;
            in_word = 0;
            if (!repeat_hit && !overflow_hit) begin
                if (kept_words >= NWORDS) begin
                    overflow_hit = 1;
                end else begin
                    for (int i = 0; i < kept_words; i++) begin
                        if (slot_equal(i)) repeat_hit = 1;
                    end
                    if (!repeat_hit) begin
                        for (int k = 0; k < NCMP; k++) stored_text[kept_words][k] = word_buf[k];
                        stored_len[kept_words] = word_len;
                        kept_words++;
                    end
                end
            end
            word_len = 0;
        endfunction

        function void note_transfer(t_in_item it);
            bit        is_newline;
            t_out_item res;
            is_newline = (it.char_byte == CHAR_NEWLINE);
            if (it.char_byte == CHAR_SPACE || is_newline) begin
                finish_word();
            end else if (!repeat_hit && !overflow_hit) begin
                in_word = 1;
                if (word_len < NCMP) begin
                    word_buf[word_len] = it.char_byte;
                    word_len++;
                end
            end
            if (!is_newline && !it.line_end) return;
            finish_word();
            res.line_valid = !repeat_hit && !overflow_hit && kept_words > 0;
            if (overflow_hit) res.status = STATUS_OVERFLOW;
            else if (kept_words == 0) res.status = STATUS_EMPTY;
            else res.status = STATUS_OK;
            if (res.line_valid && good_lines != '1) good_lines++;
            res.words_seen  = (kept_words > 31) ? SEEN_W'(31) : SEEN_W'(kept_words);
            res.valid_lines = good_lines;
            expected_q.push_back(res);
            word_len     = 0;
            kept_words   = 0;
            in_word      = 0;
            repeat_hit   = 0;
            overflow_hit = 0;
        endfunction

        function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (want === got) return 1;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            bit        ok;
            if (expected_q.size() == 0) begin
                $display("%0t: line result with none expected, got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            ok = field_ok("line_valid", 32'(want.line_valid), 32'(got.line_valid))
               & field_ok("status", 32'(want.status), 32'(got.status))
               & field_ok("words_seen", 32'(want.words_seen), 32'(got.words_seen))
               & field_ok("valid_lines", want.valid_lines, got.valid_lines);
            if (!ok) mismatches++;
            if (want.line_valid) n_good++;
            else if (want.status == STATUS_EMPTY) n_empty++;
            else if (want.status == STATUS_OVERFLOW) n_overflow++;
            else n_repeat++;
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    line_scoreboard sb = new;
    int unsigned    bytes_sent = 0;
    int unsigned    idle_cycles = 0;
    bit             in_burst = 0;
    bit             out_quiet = 0;
    bit             stall_now = 0;
    int             stall_left = 0;

    duplicate_word_line_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_item mk_item(logic [7:0] b, bit close_line);
        t_in_item it;
        it.char_byte = b;
        it.line_end  = close_line;
        return it;
    endfunction

    function automatic logic [7:0] pick_word_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CHAR_SPACE || b == CHAR_NEWLINE);
        return b;
    endfunction

    task automatic send_transfer(t_in_item it);
        int gap;
        if ($urandom_range(0, 149) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : random_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk);
        while (o_in_stall);
        sb.note_transfer(it);
        bytes_sent++;
    endtask

    task automatic send_string(string s, bit close_last);
        for (int i = 0; i < s.len(); i++) begin
            send_transfer(mk_item(s[i], close_last && i == s.len() - 1));
        end
    endtask

    task automatic random_line();
        t_in_item   line_q[$];
        logic [7:0] word[$];
        logic [7:0] first_word[$];
        logic [7:0] prefix[$];
        int         style, n_words, len, ending;
        style = $urandom_range(0, 9);
        if (style == 9) begin
            repeat ($urandom_range(5, 20)) begin
                line_q.push_back(mk_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
            end
        end else begin
            if (style <= 2) n_words = $urandom_range(1, 5);
            else if (style <= 4) n_words = $urandom_range(1, 6);
            else if (style <= 6) n_words = $urandom_range(19, 22);
            else n_words = $urandom_range(2, 3);
            repeat (NCMP) prefix.push_back(pick_word_byte());
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) line_q.push_back(mk_item(CHAR_SPACE, 0));
            end
            for (int i = 0; i < n_words; i++) begin
                word.delete();
                if (style <= 2) begin
                    repeat ($urandom_range(1, 2)) word.push_back(8'($urandom_range(97, 99)));
                end else if (style <= 6) begin
                    word.push_back(8'(128 + i));
                    repeat ($urandom_range(0, style <= 4 ? 3 : 1)) word.push_back(pick_word_byte());
                    if (i == 0) first_word = word;
                    if (i > 0 && i == n_words - 1 && $urandom_range(0, 2) == 0) word = first_word;
                end else begin
                    len = $urandom_range(18, 26);
                    for (int k = 0; k < len; k++) begin
                        word.push_back(k < NCMP ? prefix[k] : pick_word_byte());
                    end
                    if ($urandom_range(0, 1)) word[$urandom_range(0, len - 1)] = pick_word_byte();
                end
                if (i > 0) begin
                    repeat ($urandom_range(1, 3)) line_q.push_back(mk_item(CHAR_SPACE, 0));
                end
                foreach (word[k]) line_q.push_back(mk_item(word[k], 0));
            end
            ending = $urandom_range(0, 3);
            case (ending)
                0: begin
                    repeat ($urandom_range(0, 2)) line_q.push_back(mk_item(CHAR_SPACE, 0));
                    line_q.push_back(mk_item(CHAR_NEWLINE, 0));
                end
                1: line_q[$].line_end = 1'b1;
                2: line_q.push_back(mk_item(CHAR_SPACE, 1));
                default: line_q.push_back(mk_item(CHAR_NEWLINE, 1));
            endcase
        end
        foreach (line_q[i]) send_transfer(line_q[i]);
    endtask

    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) out_quiet = !out_quiet;
        if (stall_left == 0) begin
            stall_now  = out_quiet ? 1'b0 : ($urandom_range(0, 3) == 0);
            stall_left = stall_now ? random_gap() + 1 : $urandom_range(1, 6);
        end
        stall_left--;
        i_out_stall <= stall_now;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, sb.expected_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_string("\n", 0);
        send_string(" ", 1);
        send_string("a b\n", 0);
        send_string("x y x q\n", 0);
        send_transfer(mk_item(8'h00, 0));
        send_transfer(mk_item(8'hFF, 1));
        send_string("  q  \n", 1);

        while (bytes_sent < BYTE_COUNT) random_line();
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Sent %0d bytes; lines checked: %0d good, %0d repeated, %0d empty, %0d overflow",
                 bytes_sent, sb.n_good, sb.n_repeat, sb.n_empty, sb.n_overflow);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d line results mismatched", sb.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
